[rtl/ppg_pkg.sv]
// Shared types, constants and table functions of the plasma pixel generator.
package ppg_pkg;

  localparam int unsigned PixW    = 4;
  localparam int unsigned PixN    = 1 << PixW;
  localparam int unsigned TimeW   = 24;
  localparam int unsigned ModeW   = 5;
  localparam int unsigned ByteW   = 8;

  localparam int unsigned AngleW  = 26;
  localparam int unsigned CoordW  = 22;
  localparam int unsigned SineW   = 16;
  localparam int unsigned QuartW  = 15;
  localparam int unsigned DegW    = 15;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned KW      = 7;
  localparam int unsigned QuartN  = 91;

  localparam int unsigned SqW     = 44;
  localparam int unsigned RootW   = SqW / 2;
  localparam int unsigned RemW    = RootW + 4;
  localparam int unsigned SqrtLat = RootW / 2;
  localparam int unsigned SineLat = 5;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [SineW-1:0]  sine_t;
  typedef logic [ModeW-1:0]         mode_t;
  typedef logic [ByteW-1:0]         byte_t;

  typedef struct packed {
    logic          neg;
    logic [KW-1:0] k;
  } quad_t;

  localparam logic [21:0] DegPerRad = 22'd3754936;
  localparam logic [15:0] Inv360    = 16'd46603;
  localparam logic [14:0] ThirdQ16  = 15'd21845;
  localparam logic signed [18:0] PiQ16 = 19'sd205887;
  localparam angle_t Pi23Q16 = 26'sd137258;
  localparam angle_t Pi43Q16 = 26'sd274517;
  localparam coord_t CoordOfs = 22'sd131072;
  localparam sine_t  SineOne  = 16'sd16384;

  localparam mode_t MODE_SPECTRUM   = 5'd1;
  localparam mode_t MODE_AMBER      = 5'd2;
  localparam mode_t MODE_WARM       = 5'd3;
  localparam mode_t MODE_PASTEL     = 5'd4;
  localparam mode_t MODE_GRAY       = 5'd5;
  localparam mode_t MODE_MINT       = 5'd12;
  localparam mode_t MODE_CYAN_PULSE = 5'd13;
  localparam mode_t MODE_MAGENTA    = 5'd14;
  localparam mode_t MODE_MAG_PULSE  = 5'd15;
  localparam mode_t MODE_TEAL       = 5'd16;
  localparam mode_t MODE_LILAC      = 5'd17;
  localparam mode_t MODE_PURPLE     = 5'd18;
  localparam mode_t MODE_SWAP_RG    = 5'd19;
  localparam mode_t MODE_SWAP_RB    = 5'd20;
  localparam mode_t MODE_RESET      = MODE_SPECTRUM;

  localparam byte_t ByteFull = 8'hFF;
  localparam byte_t ByteGray = 8'h80;

  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int unsigned n);
    case (n)
      1:       return t / 64'd6;
      2:       return t / 64'd20;
      3:       return t / 64'd42;
      4:       return t / 64'd72;
      5:       return t / 64'd110;
      6:       return t / 64'd156;
      7:       return t / 64'd210;
      default: return t / 64'd272;
    endcase
  endfunction

  // sin(k degrees) in Q1.14 for k in 0..90, from a fixed-point Taylor series
  function automatic logic [QuartW-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * 64'd3373259426) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = taylor_div(term, n);
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    return QuartW'((sum + 64'd32768) >> 16);
  endfunction

  // fold a degree index 0..359 onto the quarter wave
  function automatic quad_t fold_idx(input logic [IdxW-1:0] idx);
    quad_t f;
    if (idx <= 9'd90) begin
      f.neg = 1'b0;
      f.k   = KW'(idx);
    end else if (idx <= 9'd180) begin
      f.neg = 1'b0;
      f.k   = KW'(9'd180 - idx);
    end else if (idx <= 9'd270) begin
      f.neg = 1'b1;
      f.k   = KW'(idx - 9'd180);
    end else begin
      f.neg = 1'b1;
      f.k   = KW'(9'd360 - idx);
    end
    return f;
  endfunction

  // (255 * (s + 1.0)) >> 15
  function automatic byte_t color_byte(input sine_t s);
    logic signed [16:0] sx;
    logic [24:0] y;
    sx = 17'(s) + 17'sd16384;
    y  = {8'd0, sx} * 25'd255;
    return y[22:15];
  endfunction

endpackage

[rtl/ppg_if.sv]
// Valid/ready channel interfaces for pixel items and color items.
interface ppg_pix_if;
  logic                      valid;
  logic                      ready;
  logic [ppg_pkg::PixW-1:0]  pixel_column;
  logic [ppg_pkg::PixW-1:0]  pixel_row;
  logic [ppg_pkg::TimeW-1:0] time_angle;

  modport source (output valid, pixel_column, pixel_row, time_angle, input ready);
  modport sink   (input valid, pixel_column, pixel_row, time_angle, output ready);
endinterface

interface ppg_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [ppg_pkg::ByteW-1:0] red;
  logic [ppg_pkg::ByteW-1:0] green;
  logic [ppg_pkg::ByteW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

[rtl/plasma_pixel_generator.sv]
// Plasma pixel generator top level: 37-stage pipeline from pixel item to color item.
// Throughput: one item per cycle; the pipeline halts as a whole only while a result is held.
// The depth is set by the chained sine table lookups and the 11-stage square root.
// Reset clears all valid bits and sets color_mode to 1; payload registers are not reset.
module plasma_pixel_generator #(
  parameter int unsigned COLUMNS = 16,
  parameter int unsigned ROWS    = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ppg_pix_if.sink         pixel_i,
  ppg_rgb_if.source       color_o,
  input  logic            cfg_we_i,
  input  ppg_pkg::mode_t  cfg_wdata_i
);
  import ppg_pkg::*;

  localparam int unsigned SC   = 1;
  localparam int unsigned SA   = 2;
  localparam int unsigned SS1  = SA + SineLat;
  localparam int unsigned SCP  = SS1 + 1;
  localparam int unsigned SSQ  = SCP + 1;
  localparam int unsigned SSUM = SSQ + 1;
  localparam int unsigned SRT  = SSUM + SqrtLat;
  localparam int unsigned SA4  = SRT + 1;
  localparam int unsigned SS4  = SA4 + SineLat;
  localparam int unsigned SV   = SS4 + 1;
  localparam int unsigned SP   = SV + 1;
  localparam int unsigned SB   = SP + 1;
  localparam int unsigned SS5  = SB + SineLat;
  localparam int unsigned SOUT = SS5 + 1;
  localparam int unsigned Depth = SOUT + 1;

  coord_t col_tab [PixN];
  coord_t row_tab [PixN];

  for (genvar g = 0; g < PixN; g++) begin : g_tab
    localparam int C0 = (g * 262144) / COLUMNS - 131072;
    localparam int C1 = (g * 262144) / ROWS - 131072;
    assign col_tab[g] = coord_t'(C0);
    assign row_tab[g] = coord_t'(C1);
  end

  logic [Depth-1:0] vld_q;
  logic             en;
  mode_t            mode_q;

  logic [PixW-1:0]  col_q, row_q;
  logic [TimeW-1:0] tp_q  [SA4];
  coord_t           c0s_q [SCP-SC];
  coord_t           c1s_q [SCP-SC];
  angle_t           a1_q, a2_q, a3_q, a5_q, a6_q, a4_q;
  coord_t           c0p_q, c1p_q;
  logic signed [17:0] vs_q [SS4-SCP+1];
  logic [41:0]      sqa_q, sqb_q;
  logic [SqW-1:0]   sq_q;
  logic signed [16:0] v_q;
  logic signed [33:0] p_q;
  angle_t           b1_q, b2_q, b3_q, b5_q;
  byte_t            red_q, green_q, blue_q;

  sine_t s1, s2, s3, s5, k6, s4, w1s, w1c, w2s, w3s, w5s;
  logic [RootW-1:0] root;

  angle_t sum_c1t, sum_ct, a2_d, a3_d, a4_d;
  logic [38:0] tthird;
  logic signed [43:0] sqa_full, sqb_full;
  logic signed [17:0] vsum;
  logic signed [16:0] v_d;
  logic signed [35:0] p_full;
  logic signed [33:0] pv_b, p5_b;
  angle_t pv, p5;
  byte_t cs1, cs2, cs4, cc1, cgray, cq;
  byte_t red_d, green_d, blue_d;

  assign en            = !vld_q[Depth-1] || color_o.ready;
  assign pixel_i.ready = en;
  assign color_o.valid = vld_q[Depth-1];
  assign color_o.red   = red_q;
  assign color_o.green = green_q;
  assign color_o.blue  = blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      mode_q <= MODE_RESET;
    end else begin
      if (en) vld_q <= {vld_q[Depth-2:0], pixel_i.valid};
      if (cfg_we_i) mode_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    sum_c1t  = angle_t'(c1s_q[0]) + angle_t'({2'b00, tp_q[SC]});
    sum_ct   = angle_t'(c0s_q[0]) + sum_c1t;
    // halve toward zero
    a2_d     = (sum_c1t + angle_t'(sum_c1t[AngleW-1])) >>> 1;
    a3_d     = (sum_ct + angle_t'(sum_ct[AngleW-1])) >>> 1;
    tthird   = {15'd0, tp_q[SC]} * {24'd0, ThirdQ16};
    sqa_full = 44'(c0p_q) * 44'(c0p_q);
    sqb_full = 44'(c1p_q) * 44'(c1p_q);
    a4_d     = angle_t'({4'd0, root}) + angle_t'({2'b00, tp_q[SRT]});
    vsum     = vs_q[SS4-SCP] + 18'(s4);
    v_d      = 17'((vsum + 18'(vsum[17])) >>> 1);
    p_full   = 36'(v_q) * 36'(PiQ16);
    pv_b     = (p_q + (p_q[33] ? 34'sd16383 : 34'sd0)) >>> 14;
    p5_b     = (p_q + (p_q[33] ? 34'sd4095 : 34'sd0)) >>> 12;
    pv       = angle_t'(pv_b);
    p5       = angle_t'(p5_b);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q   <= pixel_i.pixel_column;
      row_q   <= pixel_i.pixel_row;
      tp_q[0] <= pixel_i.time_angle;
      for (int n = 1; n < SA4; n++) tp_q[n] <= tp_q[n-1];

      c0s_q[0] <= col_tab[col_q];
      c1s_q[0] <= row_tab[row_q];
      for (int n = 1; n < SCP - SC; n++) begin
        c0s_q[n] <= c0s_q[n-1];
        c1s_q[n] <= c1s_q[n-1];
      end

      a1_q <= angle_t'(c0s_q[0]) + angle_t'({2'b00, tp_q[SC]});
      a2_q <= a2_d;
      a3_q <= a3_d;
      a5_q <= angle_t'({3'd0, tthird[38:16]});
      a6_q <= angle_t'({3'd0, tp_q[SC][TimeW-1:1]});

      c0p_q <= c0s_q[SS1-SC] + (coord_t'(s5) <<< 3);
      c1p_q <= c1s_q[SS1-SC] + (coord_t'(k6) <<< 3);
      vs_q[0] <= 18'(s1) + 18'(s2) + 18'(s3);
      for (int n = 1; n <= SS4 - SCP; n++) vs_q[n] <= vs_q[n-1];

      sqa_q <= sqa_full[41:0];
      sqb_q <= sqb_full[41:0];
      sq_q  <= {2'b00, sqa_q} + {2'b00, sqb_q} + 44'h1_0000_0000;

      a4_q <= a4_d;
      v_q  <= v_d;
      p_q  <= p_full[33:0];
      b1_q <= pv;
      b2_q <= pv + Pi23Q16;
      b3_q <= pv + Pi43Q16;
      b5_q <= p5;

      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  ppg_sine u_sin1 (.clk_i, .en_i(en), .angle_i(a1_q), .sin_o(s1),  .cos_o());
  ppg_sine u_sin2 (.clk_i, .en_i(en), .angle_i(a2_q), .sin_o(s2),  .cos_o());
  ppg_sine u_sin3 (.clk_i, .en_i(en), .angle_i(a3_q), .sin_o(s3),  .cos_o());
  ppg_sine u_sin5 (.clk_i, .en_i(en), .angle_i(a5_q), .sin_o(s5),  .cos_o());
  ppg_sine u_cos6 (.clk_i, .en_i(en), .angle_i(a6_q), .sin_o(),    .cos_o(k6));
  ppg_sine u_sin4 (.clk_i, .en_i(en), .angle_i(a4_q), .sin_o(s4),  .cos_o());
  ppg_sine u_pal1 (.clk_i, .en_i(en), .angle_i(b1_q), .sin_o(w1s), .cos_o(w1c));
  ppg_sine u_pal2 (.clk_i, .en_i(en), .angle_i(b2_q), .sin_o(w2s), .cos_o());
  ppg_sine u_pal3 (.clk_i, .en_i(en), .angle_i(b3_q), .sin_o(w3s), .cos_o());
  ppg_sine u_pal5 (.clk_i, .en_i(en), .angle_i(b5_q), .sin_o(w5s), .cos_o());

  ppg_sqrt u_sqrt (.clk_i, .en_i(en), .rad_i(sq_q), .root_o(root));

  always_comb begin
    cs1   = color_byte(w1s);
    cs2   = color_byte(w2s);
    cs4   = color_byte(w3s);
    cc1   = color_byte(w1c);
    cgray = color_byte(w5s);
    // squared-color truncation: only a full-scale sine survives as 1
    cq    = (w3s == SineOne) ? 8'd1 : 8'd0;
    case (mode_q)
      MODE_SPECTRUM:   begin red_d = cs1;      green_d = cs2;      blue_d = cs4;      end
      MODE_SWAP_RG:    begin red_d = cs2;      green_d = cs1;      blue_d = cs4;      end
      MODE_SWAP_RB:    begin red_d = cs4;      green_d = cs2;      blue_d = cs1;      end
      MODE_PASTEL:     begin red_d = ByteFull; green_d = ByteFull; blue_d = cs4;      end
      MODE_AMBER:      begin red_d = cs1;      green_d = cc1;      blue_d = '0;       end
      MODE_TEAL:       begin red_d = '0;       green_d = cc1;      blue_d = cs1;      end
      MODE_PURPLE:     begin red_d = cs1;      green_d = '0;       blue_d = cc1;      end
      MODE_WARM:       begin red_d = ByteFull; green_d = cc1;      blue_d = cs1;      end
      MODE_MINT:       begin red_d = cs1;      green_d = ByteFull; blue_d = cc1;      end
      MODE_LILAC:      begin red_d = cs1;      green_d = cc1;      blue_d = ByteFull; end
      MODE_MAGENTA:    begin red_d = ByteFull; green_d = cs1;      blue_d = ByteFull; end
      MODE_GRAY:       begin red_d = cgray;    green_d = cgray;    blue_d = cgray;    end
      MODE_CYAN_PULSE: begin red_d = cq;       green_d = ByteFull; blue_d = ByteFull; end
      MODE_MAG_PULSE:  begin red_d = ByteFull; green_d = cq;       blue_d = ByteFull; end
      default:         begin red_d = ByteGray; green_d = ByteGray; blue_d = ByteGray; end
    endcase
  end

endmodule

[rtl/ppg_sine.sv]
// Pipelined sine and cosine lookup of a Q.16 radian angle through a degree table.
module ppg_sine (
  input  logic            clk_i,
  input  logic            en_i,
  input  ppg_pkg::angle_t angle_i,
  output ppg_pkg::sine_t  sin_o,
  output ppg_pkg::sine_t  cos_o
);
  import ppg_pkg::*;

  logic [QuartW-1:0] qrom [QuartN];

  for (genvar g = 0; g < QuartN; g++) begin : g_rom
    assign qrom[g] = quarter_sine(g);
  end

  logic                 neg1_q, neg2_q;
  logic [DegW-1:0]      deg1_q, deg2_q;
  logic [KW-1:0]        q2_q;
  logic [IdxW-1:0]      idx3_q;
  quad_t                fs4_q, fc4_q;
  sine_t                sin_q, cos_q;

  logic [AngleW-1:0]    mag;
  logic [AngleW+21:0]   prod;
  logic [DegW+15:0]     qprod;
  logic [DegW-1:0]      rem_full;
  logic [IdxW:0]        rem_lo;
  logic [IdxW-1:0]      rem_w, idx_d, cidx;
  logic [IdxW:0]        cidx_sum;

  always_comb begin
    mag      = angle_i[AngleW-1] ? AngleW'(-angle_i) : AngleW'(angle_i);
    prod     = {22'd0, mag} * {{AngleW{1'b0}}, DegPerRad};
    qprod    = {16'd0, deg1_q} * {{DegW{1'b0}}, Inv360};
    // quotient may fall one short, so the remainder stays below 720
    rem_full = deg2_q - DegW'({8'd0, q2_q} * 15'd360);
    rem_lo   = rem_full[IdxW:0];
    rem_w    = (rem_lo >= 10'd360) ? IdxW'(rem_lo - 10'd360) : IdxW'(rem_lo);
    idx_d    = (neg2_q && rem_w != '0) ? IdxW'(9'd360 - rem_w) : rem_w;
    cidx_sum = {1'b0, idx3_q} + 10'd90;
    cidx     = (cidx_sum >= 10'd360) ? IdxW'(cidx_sum - 10'd360) : IdxW'(cidx_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= angle_i[AngleW-1];
      deg1_q <= prod[32 +: DegW];
      neg2_q <= neg1_q;
      deg2_q <= deg1_q;
      q2_q   <= qprod[24 +: KW];
      idx3_q <= idx_d;
      fs4_q  <= fold_idx(idx3_q);
      fc4_q  <= fold_idx(cidx);
      sin_q  <= fs4_q.neg ? -sine_t'({1'b0, qrom[fs4_q.k]}) : sine_t'({1'b0, qrom[fs4_q.k]});
      cos_q  <= fc4_q.neg ? -sine_t'({1'b0, qrom[fc4_q.k]}) : sine_t'({1'b0, qrom[fc4_q.k]});
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

[rtl/ppg_sqrt.sv]
// Pipelined floor square root, two result bits per stage.
module ppg_sqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ppg_pkg::SqW-1:0]  rad_i,
  output logic [ppg_pkg::RootW-1:0] root_o
);
  import ppg_pkg::*;

  logic [RemW-1:0]  rem_q  [SqrtLat];
  logic [RootW-1:0] root_q [SqrtLat];
  logic [SqW-1:0]   rad_q  [SqrtLat];

  function automatic logic [RemW+RootW-1:0] sq_step(input logic [RemW-1:0] rem,
                                                   input logic [RootW-1:0] root,
                                                   input logic [1:0] pair);
    logic [RemW-1:0] r;
    logic [RemW-1:0] trial;
    r     = {rem[RemW-3:0], pair};
    trial = {2'b00, root, 2'b01};
    if (r >= trial) return {r - trial, root[RootW-2:0], 1'b1};
    else            return {r, root[RootW-2:0], 1'b0};
  endfunction

  for (genvar j = 0; j < SqrtLat; j++) begin : g_stage
    logic [RemW-1:0]       rem_in;
    logic [RootW-1:0]      root_in;
    logic [SqW-1:0]        rad_in;
    logic [RemW+RootW-1:0] mid, fin;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    always_comb begin
      mid = sq_step(rem_in, root_in, rad_in[SqW-1 -: 2]);
      fin = sq_step(mid[RootW +: RemW], mid[RootW-1:0], rad_in[SqW-3 -: 2]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fin[RootW +: RemW];
        root_q[j] <= fin[RootW-1:0];
        rad_q[j]  <= {rad_in[SqW-5:0], 4'd0};
      end
    end
  end

  assign root_o = root_q[SqrtLat-1];

endmodule

[rtl/ppg_checker.sv]
// Port-level checker of the plasma pixel generator, bound to the top level.
module ppg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [ppg_pkg::ByteW-1:0] red_i,
  input logic [ppg_pkg::ByteW-1:0] green_i,
  input logic [ppg_pkg::ByteW-1:0] blue_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(red_i) && $stable(green_i) && $stable(blue_i))
    else $error("result item changed while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input refused while no result is held");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while pipeline is stalled");

endmodule

bind plasma_pixel_generator ppg_checker u_ppg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pixel_i.ready),
  .out_valid_i (color_o.valid),
  .out_ready_i (color_o.ready),
  .red_i       (color_o.red),
  .green_i     (color_o.green),
  .blue_i      (color_o.blue)
);
